### rtl/core/tpe_pkg.sv
package tpe_pkg;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_CANCEL = 3'd1,
    REQ_QUERY  = 3'd2,
    REQ_STEP   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  localparam int RES_MAX = 16;
  localparam int CNT_MAX = 31;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  owner_id;
    logic [7:0]  event_id;
    logic [31:0] start_delay;
    logic [31:0] reload_period;
    logic [31:0] elapsed_time;
    logic        post_ready;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [4:0] match_count;
    logic       is_armed;
    logic       fired;
    logic [7:0] fired_owner;
    logic [7:0] fired_event;
    logic       last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic walk_rd;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_last;
  } sts_t;

endpackage

### rtl/core/tpe_ram.sv
module tpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tpe_ctrl.sv
module tpe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    req_type,
  input  tpe_pkg::sts_t sts,
  output tpe_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [1:0] {IDLE, WALK, DRAIN, FINISH} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            if (req_type inside {tpe_pkg::REQ_CANCEL, tpe_pkg::REQ_QUERY,
                                 tpe_pkg::REQ_STEP}) begin
              state <= WALK;
            end else begin
              state <= FINISH;
            end
          end
        end
        WALK: begin
          if (sts.rd_last) begin
            state <= DRAIN;
          end
        end
        DRAIN:   state <= FINISH;
        FINISH:  state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.latch   = (state == IDLE) && start;
    cmd.walk_rd = (state == WALK);
    cmd.finish  = (state == FINISH);
    busy        = (state != IDLE);
  end

endmodule

### rtl/core/tpe_dpath.sv
module tpe_dpath #(
  parameter int SLOT_COUNT = 16,
  parameter int ID_WIDTH   = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  tpe_pkg::req_t req,
  input  tpe_pkg::cmd_t cmd,
  output tpe_pkg::sts_t sts,
  output tpe_pkg::res_t result,
  output logic          done
);

  localparam int AW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int WW = 2 * ID_WIDTH + 64;

  tpe_pkg::req_t req_q;
  logic [SLOT_COUNT-1:0] used;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx;
  logic          rd_vld;
  logic [CW-1:0] match_cnt;
  logic [4:0]    fire_cnt;
  logic          pend_vld;
  logic [7:0]    pend_owner;
  logic [7:0]    pend_event;

  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata;
  logic [WW-1:0] rdata;

  logic [ID_WIDTH-1:0] own_m, ev_m, r_own, r_ev;
  logic [31:0] r_rem, r_per, rem_sub;
  logic        slot_live, fire_now, match_now, found;
  logic [AW-1:0] free_idx;
  logic [4:0]  cnt_sat;
  tpe_pkg::res_t res_fin;

  tpe_ram #(.WIDTH(WW), .DEPTH(SLOT_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  always_comb begin
    own_m = ID_WIDTH'(req_q.owner_id);
    ev_m  = ID_WIDTH'(req_q.event_id);
    {r_own, r_ev, r_rem, r_per} = rdata;
    rem_sub   = (req_q.elapsed_time >= r_rem) ? 32'd0 : r_rem - req_q.elapsed_time;
    slot_live = rd_vld && used[wr_idx];
    fire_now  = slot_live && req_q.req_type == tpe_pkg::REQ_STEP && rem_sub == 32'd0 &&
                req_q.post_ready && (32'(fire_cnt) < tpe_pkg::RES_MAX);
    match_now = slot_live && r_own == own_m && r_ev == ev_m;
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found    = 1'b1;
        free_idx = AW'(i);
      end
    end
    cnt_sat = (32'(match_cnt) > tpe_pkg::CNT_MAX) ? 5'(tpe_pkg::CNT_MAX) : 5'(match_cnt);
    if (cmd.finish) begin
      we    = req_q.req_type == tpe_pkg::REQ_ADD && found;
      waddr = free_idx;
      wdata = {own_m, ev_m, req_q.start_delay, req_q.reload_period};
    end else begin
      we    = slot_live && req_q.req_type == tpe_pkg::REQ_STEP;
      waddr = wr_idx;
      wdata = {r_own, r_ev, (fire_now ? r_per : rem_sub), r_per};
    end
    sts.rd_last = (rd_idx == AW'(SLOT_COUNT - 1));
    // final result of the request
    res_fin = '0;
    res_fin.last = 1'b1;
    case (req_q.req_type)
      tpe_pkg::REQ_ADD:    res_fin.status = !found;
      tpe_pkg::REQ_CANCEL: res_fin.match_count = cnt_sat;
      tpe_pkg::REQ_QUERY: begin
        res_fin.match_count = cnt_sat;
        res_fin.is_armed    = (match_cnt != '0);
      end
      tpe_pkg::REQ_STEP: begin
        if (pend_vld) begin
          res_fin.fired       = 1'b1;
          res_fin.fired_owner = pend_owner;
          res_fin.fired_event = pend_event;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      rd_vld <= cmd.walk_rd;
      wr_idx <= rd_idx;
      if (cmd.latch) begin
        req_q     <= req;
        rd_idx    <= '0;
        match_cnt <= '0;
        fire_cnt  <= '0;
        pend_vld  <= 1'b0;
      end else if (cmd.walk_rd) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (rd_vld && req_q.req_type != tpe_pkg::REQ_STEP && match_now) begin
        match_cnt <= match_cnt + CW'(1);
        if (req_q.req_type == tpe_pkg::REQ_CANCEL) begin
          used[wr_idx] <= 1'b0;
        end
      end
      if (fire_now) begin
        fire_cnt   <= fire_cnt + 5'd1;
        pend_vld   <= 1'b1;
        pend_owner <= 8'(r_own);
        pend_event <= 8'(r_ev);
        if (r_per == 32'd0) begin
          used[wr_idx] <= 1'b0;
        end
      end
      // hold one fired event back so the final one can carry last
      if (fire_now && pend_vld) begin
        done   <= 1'b1;
        result <= '{status: 1'b0, match_count: 5'd0, is_armed: 1'b0, fired: 1'b1,
                    fired_owner: pend_owner, fired_event: pend_event, last: 1'b0};
      end else if (cmd.finish) begin
        done   <= 1'b1;
        result <= res_fin;
      end else begin
        done <= 1'b0;
      end
      if (cmd.finish) begin
        case (req_q.req_type)
          tpe_pkg::REQ_ADD: begin
            if (found) begin
              used[free_idx] <= 1'b1;
            end
          end
          tpe_pkg::REQ_CLEAR: used <= '0;
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/core/timer_pool_engine.sv
// Add, clear and unknown requests go from IDLE to FINISH, which registers the result;
// cancel, query and step walk each slot in WALK, one slot a cycle through the slot
// RAM's single read port, then pass DRAIN and FINISH. busy stays high until the last
// result. Each fired event waits for a later fire or the end, where it carries last.
// A new request is taken only while idle. Synchronous reset empties the pool.
// Results are strobed by done for one cycle; the receiver cannot stall.
module timer_pool_engine #(
  parameter int SLOT_COUNT = 16,
  parameter int ID_WIDTH   = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tpe_pkg::req_t req,
  output tpe_pkg::res_t result,
  output logic          done
);

  tpe_pkg::cmd_t cmd;
  tpe_pkg::sts_t sts;

  tpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  tpe_dpath #(.SLOT_COUNT(SLOT_COUNT), .ID_WIDTH(ID_WIDTH)) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .sts    (sts),
    .result (result),
    .done   (done)
  );

endmodule

### rtl/core/tpe_checker.sv
module tpe_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input tpe_pkg::res_t result,
  input logic          done
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after transfer");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && result.last |-> !busy ##1 !done) else $error("still busy after last result");

  a_mid_fired: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> result.fired) else $error("non-final result without event");

  a_no_idle_result: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !done) else $error("result without request");

  a_fired_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.fired |-> !result.status && result.match_count == 5'd0)
    else $error("fired result carries other fields");

endmodule

bind timer_pool_engine tpe_checker u_tpe_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .done   (done)
);
